/* rtl/cfb_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte update for the command frame builder.
// No dependencies; used by the front end, queue, back end and top level.
package cfb_pkg;

    localparam logic [7:0]  START_BYTE_RST     = 8'hA5;
    localparam int unsigned MAX_DATA_BYTES_DEF = 510;
    localparam logic [15:0] CRC_POLY           = 16'h1021;
    localparam int unsigned QUEUE_DEPTH        = 4;
    localparam int unsigned HDR_BYTES          = 6;
    localparam logic [3:0]  STEP_HCRC_HI       = 4'd6;
    localparam logic [3:0]  STEP_HCRC_LO       = 4'd7;
    localparam logic [3:0]  STEP_ZERO_LO       = 4'd9;
    localparam logic [3:0]  STEP_DCRC_HI       = 4'd1;
    localparam logic [3:0]  STEP_DCRC_LO       = 4'd2;

    typedef enum logic [1:0] {
        K_HDR   = 2'd0,
        K_DATA  = 2'd1,
        K_DLAST = 2'd2,
        K_ERR   = 2'd3
    } t_kind;

    // b[0..5]: header bytes; for data jobs b[0] is the byte, and on the last one b[1]/b[2] the data CRC
    typedef struct packed {
        t_kind                  kind;
        logic                   zlen;
        logic [5:0][7:0]        b;
    } t_job;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* rtl/cfb_front.sv */
`timescale 1ns / 1ps
// Front end: takes input beats, tracks the open frame and the data CRC, emits one job per beat.
// Depends on cfb_pkg.
module cfb_front #(
    parameter int unsigned MAX_DATA_BYTES = cfb_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic [7:0]    i_address,
    input  logic [3:0]    i_sequence_req,
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_index,
    input  logic [7:0]    i_offset,
    input  logic [8:0]    i_payload_len,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_full,
    output logic          o_push,
    output cfb_pkg::t_job o_job
);

    logic [7:0]  r_start_byte;
    logic [15:0] r_crc_acc, n_crc_acc;
    logic [8:0]  r_bytes_left, n_bytes_left;
    logic [8:0]  len_sat;
    logic [8:0]  left_dec;
    logic [15:0] crc_next;

    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full;
    assign len_sat  = (i_payload_len > 9'(MAX_DATA_BYTES)) ? 9'(MAX_DATA_BYTES) : i_payload_len;
    assign left_dec = r_bytes_left - 9'd1;
    assign crc_next = cfb_pkg::crc_update(r_crc_acc, i_data_byte);

    always_comb begin
        n_crc_acc    = r_crc_acc;
        n_bytes_left = r_bytes_left;
        o_job.kind   = cfb_pkg::K_ERR;
        o_job.zlen   = 1'b0;
        o_job.b      = '0;
        if (!i_op) begin
            o_job.kind   = cfb_pkg::K_HDR;
            o_job.zlen   = (len_sat == 9'd0);
            o_job.b[0]   = r_start_byte;
            o_job.b[1]   = i_address;
            o_job.b[2]   = {2'b00, i_sequence_req, i_command};
            o_job.b[3]   = i_index;
            o_job.b[4]   = i_offset;
            o_job.b[5]   = len_sat[8:1];
            n_crc_acc    = '0;
            n_bytes_left = len_sat;
        end else if (r_bytes_left != 9'd0) begin
            o_job.b[0]   = i_data_byte;
            n_bytes_left = left_dec;
            if (left_dec == 9'd0) begin
                o_job.kind = cfb_pkg::K_DLAST;
                o_job.b[1] = crc_next[15:8];
                o_job.b[2] = crc_next[7:0];
                n_crc_acc  = '0;
            end else begin
                o_job.kind = cfb_pkg::K_DATA;
                n_crc_acc  = crc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= cfb_pkg::START_BYTE_RST;
            r_crc_acc    <= '0;
            r_bytes_left <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_start_byte <= i_cfg_data;
            end
            if (o_push) begin
                r_crc_acc    <= n_crc_acc;
                r_bytes_left <= n_bytes_left;
            end
        end
    end

endmodule

/* rtl/cfb_queue.sv */
`timescale 1ns / 1ps
// Short job queue between front and back end, flop based, head shown combinationally.
// Depends on cfb_pkg.
module cfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output cfb_pkg::t_job o_head
);

    localparam int unsigned PtrW = $clog2(cfb_pkg::QUEUE_DEPTH);

    cfb_pkg::t_job r_mem [cfb_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PtrW:0]   r_count;

    assign o_full       = (r_count == (PtrW+1)'(cfb_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/cfb_back.sv */
`timescale 1ns / 1ps
// Back end: walks the head job byte by byte into the output register, header CRC on the fly.
// Depends on cfb_pkg.
module cfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  cfb_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_error
);

    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_oerr;
    logic [3:0]  r_step;
    logic [15:0] r_hcrc;
    logic        advance;
    logic        fire;
    logic        final_step;
    logic [7:0]  n_byte;
    logic        n_last;
    logic        n_err;
    logic        hdr_byte;

    assign advance  = !r_ovalid || i_ready;
    assign fire     = advance && i_head_valid;
    assign o_pop    = fire && final_step;
    assign hdr_byte = (i_head.kind == cfb_pkg::K_HDR) && (r_step < 4'(cfb_pkg::HDR_BYTES));

    assign o_valid  = r_ovalid;
    assign o_byte   = r_obyte;
    assign o_last   = r_olast;
    assign o_error  = r_oerr;

    always_comb begin
        n_byte     = 8'h00;
        n_last     = 1'b0;
        n_err      = 1'b0;
        final_step = 1'b1;
        unique case (i_head.kind)
            cfb_pkg::K_HDR: begin
                final_step = i_head.zlen ? (r_step == cfb_pkg::STEP_ZERO_LO)
                                         : (r_step == cfb_pkg::STEP_HCRC_LO);
                n_last     = (r_step == cfb_pkg::STEP_ZERO_LO);
                if (hdr_byte) begin
                    n_byte = i_head.b[r_step[2:0]];
                end else if (r_step == cfb_pkg::STEP_HCRC_HI) begin
                    n_byte = r_hcrc[15:8];
                end else if (r_step == cfb_pkg::STEP_HCRC_LO) begin
                    n_byte = r_hcrc[7:0];
                end
            end
            cfb_pkg::K_DATA: begin
                n_byte = i_head.b[0];
            end
            cfb_pkg::K_DLAST: begin
                final_step = (r_step == cfb_pkg::STEP_DCRC_LO);
                n_last     = final_step;
                priority if (r_step == cfb_pkg::STEP_DCRC_LO) begin
                    n_byte = i_head.b[2];
                end else if (r_step == cfb_pkg::STEP_DCRC_HI) begin
                    n_byte = i_head.b[1];
                end else begin
                    n_byte = i_head.b[0];
                end
            end
            cfb_pkg::K_ERR: begin
                n_last = 1'b1;
                n_err  = 1'b1;
            end
            default: begin
                n_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_obyte <= n_byte;
            r_olast <= n_last;
            r_oerr  <= n_err;
        end
        if (fire && hdr_byte) begin
            r_hcrc <= cfb_pkg::crc_update((r_step == 4'd0) ? 16'h0000 : r_hcrc, n_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_step   <= '0;
        end else if (advance) begin
            r_ovalid <= i_head_valid;
            if (fire) begin
                r_step <= final_step ? 4'd0 : r_step + 4'd1;
            end
        end
    end

endmodule

/* rtl/command_frame_builder_crc16_core.sv */
`timescale 1ns / 1ps
// Command frame builder with CRC-16/XMODEM: top level joining front end, job queue and back end.
// Depends on cfb_pkg, cfb_front, cfb_queue, cfb_back.
//
// Usage:
//   s_axis carries input beats: tuser[0] = 0 starts a frame from the header fields,
//   tuser[0] = 1 carries one payload byte. m_axis gives one frame byte per beat,
//   tlast on the final byte of a frame or on an error beat, tuser[0] on an error.
//   A header beat yields eight output beats (ten when the length is zero); a payload
//   beat yields one, or three for the last byte of a frame (two data CRC bytes follow).
//   The cfg channel writes the start byte; ready is always high. Write it only when idle.
// Order and rate:
//   m_axis_tvalid rises once the job has passed the queue write and then the output
//   register. Input beats are taken one per cycle while the four-entry job queue has
//   room; the back end drains one output byte per cycle while m_axis_tready is high,
//   so sustained rate is set by the back end's byte count per job.
// Reset:
//   Synchronous, active low. Clears the queue, the output valid and step, the open frame and
//   the data CRC; the start byte returns to 0xA5.
// Stall:
//   A stalled m_axis holds its beat; the queue fills and then s_axis_tready drops.
module command_frame_builder_crc16_core #(
    parameter int unsigned MAX_DATA_BYTES = cfb_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[7:0], sequence_req[11:8], command[13:12], index[21:14], offset[29:22],
    // payload_len[38:30], data_byte[46:39], zero[47]
    input  logic [47:0] s_axis_tdata,
    // op[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    // error[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;
    cfb_pkg::t_job job;
    cfb_pkg::t_job head;

    assign o_cfg_ready = 1'b1;

    cfb_front #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_op           (s_axis_tuser[0]),
        .i_address      (s_axis_tdata[7:0]),
        .i_sequence_req (s_axis_tdata[11:8]),
        .i_command      (s_axis_tdata[13:12]),
        .i_index        (s_axis_tdata[21:14]),
        .i_offset       (s_axis_tdata[29:22]),
        .i_payload_len  (s_axis_tdata[38:30]),
        .i_data_byte    (s_axis_tdata[46:39]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_full         (full),
        .o_push         (push),
        .o_job          (job)
    );

    cfb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    cfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_error      (m_axis_tuser[0])
    );

endmodule

/* rtl/cfb_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the output stream of the frame builder, bound to the top level.
// Depends on command_frame_builder_crc16_core.
module cfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [0:0] m_axis_tuser
);

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("error beat without tlast");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
        else $error("error beat with non-zero byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled beat changed");

endmodule

bind command_frame_builder_crc16_core cfb_checker u_cfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
